### src/qpe_pkg.sv
`timescale 1ns / 1ps
// qpe_pkg: pixel type, QOI chunk tags and colour hash for the QOI pixel encoder.
package qpe_pkg;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pixel_t;

	localparam logic [7:0] ChunkIndex = 8'h00;
	localparam logic [7:0] ChunkDiff  = 8'h40;
	localparam logic [7:0] ChunkLuma  = 8'h80;
	localparam logic [7:0] ChunkRun   = 8'hC0;
	localparam logic [7:0] ChunkRgb   = 8'hFE;
	localparam logic [7:0] ChunkRgba  = 8'hFF;

	localparam int unsigned TableDepth = 64;
	localparam int unsigned SlotW      = 6;
	localparam int unsigned MaxBytes   = 6;
	localparam int unsigned CountW     = 3;

	// QOI start pixel: black, fully opaque
	localparam pixel_t StartPixel = '{r: 8'h00, g: 8'h00, b: 8'h00, a: 8'hFF};

	// (r*3 + g*5 + b*7 + a*11) mod 64, only the low six bits matter
	function automatic logic [SlotW-1:0] qpe_hash(input pixel_t p);
		logic [SlotW-1:0] hr;
		logic [SlotW-1:0] hg;
		logic [SlotW-1:0] hb;
		logic [SlotW-1:0] ha;
		hr = p.r[5:0] + {p.r[4:0], 1'b0};
		hg = p.g[5:0] + {p.g[3:0], 2'b00};
		hb = {p.b[2:0], 3'b000} - p.b[5:0];
		ha = {p.a[2:0], 3'b000} + {p.a[4:0], 1'b0} + p.a[5:0];
		return hr + hg + hb + ha;
	endfunction

endpackage

### src/qoi_pixel_encoder_core.sv
`timescale 1ns / 1ps
// qoi_pixel_encoder_core: streaming QOI chunk encoder, pixel in, chunk bytes out.
//
//   channel | handshake           | payload                       | beat
//   --------+---------------------+-------------------------------+----------------------
//   in      | in_valid / in_stall | op, red, green, blue, alpha   | one pixel or a flush
//   out     | out_valid/out_stall | code_byte, last_byte          | one chunk byte
//
// Pipeline: two stages. At the accept edge the colour hash addresses the 64-entry
//   colour table (synchronous read). Stage 1 has the table entry, previous pixel and
//   run count, picks the chunk and updates state. Stage 2 holds up to six bytes and
//   shifts out one byte per cycle while out_stall is low; then an item is accepted
//   every cycle while each pixel yields at most one byte; longer items hold the input.
// Reset: table entries are tagged by 64 valid flops cleared at once (no clearing pass);
//   flush clears them too.
// Stalls: out_stall holds stage 2; a stage 1 item with bytes holds, raising in_stall.
module qoi_pixel_encoder_core #(
	parameter int RUN_LIMIT = 62
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	input  logic [7:0] alpha,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] code_byte,
	output logic       last_byte
);
	import qpe_pkg::*;

	localparam logic [6:0] RunLimitW = 7'(RUN_LIMIT);

	// ---------------------------------------------------------------
	// Colour table memory (write at stage 1, read at accept edge)
	// ---------------------------------------------------------------
	pixel_t            table_mem [TableDepth];
	logic [TableDepth-1:0] entry_vld_q;

	// last table write, forwarded when the read raced it
	logic              last_wr_vld_q;
	logic [SlotW-1:0]  last_wr_slot_q;
	pixel_t            last_wr_px_q;

	// stage 1
	logic              valid_s1;
	logic              flush_s1;
	pixel_t            px_s1;
	logic [SlotW-1:0]  slot_s1;
	pixel_t            rd_data_s1;

	// architectural state
	pixel_t            prev_q;
	logic [5:0]        run_q;

	// stage 2: byte shifter
	logic [MaxBytes-1:0][7:0] bytes_s2;
	logic [CountW-1:0]        rem_s2;

	pixel_t            in_px;
	logic [SlotW-1:0]  in_slot;
	logic              in_fire;
	logic              out_fire;
	logic              s2_free;
	logic              adv_s1;

	// stage 1 decode
	pixel_t            entry;
	logic              same_prev;
	logic              run_pend;
	logic [6:0]        run_inc;
	logic              run_hit_limit;
	logic [7:0]        dr, dg, db;
	logic [7:0]        dr_p2, dg_p2, db_p2, dg_p32;
	logic signed [9:0] dgr, dgb;
	logic [9:0]        dgr_p8, dgb_p8;
	logic              diff_ok, luma_ok;
	logic [4:0][7:0]   cb;
	logic [CountW-1:0] clen;
	logic [MaxBytes-1:0][7:0] nb;
	logic [CountW-1:0] nbytes;
	logic [5:0]        run_next;
	logic              tbl_wr;

	assign in_px   = '{r: red, g: green, b: blue, a: alpha};
	assign in_slot = qpe_hash(in_px);

	assign out_valid = (rem_s2 != '0);
	assign out_fire  = out_valid && !out_stall;
	assign code_byte = bytes_s2[0];
	assign last_byte = (rem_s2 == CountW'(1));
	assign s2_free   = (rem_s2 == '0) || (out_fire && rem_s2 == CountW'(1));

	assign adv_s1   = valid_s1 && ((nbytes == '0) || s2_free);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_fire  = in_valid && !in_stall;

	// ---------------------------------------------------------------
	// Stage 1: chunk selection
	// ---------------------------------------------------------------
	always_comb begin
		// forwarded entry; an entry never written since reset/flush reads zero
		if (!entry_vld_q[slot_s1]) begin
			entry = '0;
		end else if (last_wr_vld_q && last_wr_slot_q == slot_s1) begin
			entry = last_wr_px_q;
		end else begin
			entry = rd_data_s1;
		end

		same_prev     = (px_s1 == prev_q);
		run_pend      = (run_q != '0);
		run_inc       = {1'b0, run_q} + 7'd1;
		run_hit_limit = (run_inc >= RunLimitW);

		// wrapped byte deltas
		dr = px_s1.r - prev_q.r;
		dg = px_s1.g - prev_q.g;
		db = px_s1.b - prev_q.b;
		dr_p2  = dr + 8'd2;
		dg_p2  = dg + 8'd2;
		db_p2  = db + 8'd2;
		dg_p32 = dg + 8'd32;
		dgr = $signed({{2{dr[7]}}, dr}) - $signed({{2{dg[7]}}, dg});
		dgb = $signed({{2{db[7]}}, db}) - $signed({{2{dg[7]}}, dg});
		dgr_p8 = 10'(dgr + 10'sd8);
		dgb_p8 = 10'(dgb + 10'sd8);
		diff_ok = (dr_p2[7:2] == '0) && (dg_p2[7:2] == '0) && (db_p2[7:2] == '0);
		luma_ok = (dg_p32[7:6] == '0) && (dgr_p8[9:4] == '0) && (dgb_p8[9:4] == '0);

		cb   = '0;
		clen = '0;
		if (entry == px_s1) begin
			cb[0] = ChunkIndex | {2'b00, slot_s1};
			clen  = CountW'(1);
		end else if (px_s1.a == prev_q.a) begin
			if (diff_ok) begin
				cb[0] = ChunkDiff | {2'b00, dr_p2[1:0], dg_p2[1:0], db_p2[1:0]};
				clen  = CountW'(1);
			end else if (luma_ok) begin
				cb[0] = ChunkLuma | {2'b00, dg_p32[5:0]};
				cb[1] = {dgr_p8[3:0], dgb_p8[3:0]};
				clen  = CountW'(2);
			end else begin
				cb[0] = ChunkRgb;
				cb[1] = px_s1.r;
				cb[2] = px_s1.g;
				cb[3] = px_s1.b;
				clen  = CountW'(4);
			end
		end else begin
			cb[0] = ChunkRgba;
			cb[1] = px_s1.r;
			cb[2] = px_s1.g;
			cb[3] = px_s1.b;
			cb[4] = px_s1.a;
			clen  = CountW'(5);
		end

		nb       = '0;
		nbytes   = '0;
		run_next = run_q;
		tbl_wr   = 1'b0;
		if (flush_s1) begin
			// pending run goes out, state returns to reset
			nb[0]    = ChunkRun | {2'b00, run_q - 6'd1};
			nbytes   = run_pend ? CountW'(1) : '0;
			run_next = '0;
		end else if (same_prev) begin
			if (run_hit_limit) begin
				nb[0]    = ChunkRun | {2'b00, run_q};
				nbytes   = CountW'(1);
				run_next = '0;
			end else begin
				run_next = run_inc[5:0];
			end
		end else begin
			tbl_wr   = 1'b1;
			run_next = '0;
			if (run_pend) begin
				nb[0]   = ChunkRun | {2'b00, run_q - 6'd1};
				nb[5:1] = cb;
				nbytes  = clen + CountW'(1);
			end else begin
				nb[4:0] = cb;
				nbytes  = clen;
			end
		end
	end

	// table storage: no reset, read-before-write
	always_ff @(posedge clk) begin
		if (in_fire) begin
			rd_data_s1 <= table_mem[in_slot];
		end
		if (adv_s1 && tbl_wr) begin
			table_mem[slot_s1] <= px_s1;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			flush_s1 <= op;
			px_s1    <= in_px;
			slot_s1  <= in_slot;
		end
		if (adv_s1 && tbl_wr) begin
			last_wr_slot_q <= slot_s1;
			last_wr_px_q   <= px_s1;
		end
	end

	// control and encoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			prev_q        <= StartPixel;
			run_q         <= '0;
			entry_vld_q   <= '0;
			last_wr_vld_q <= 1'b0;
		end else begin
			valid_s1 <= in_fire || (valid_s1 && !adv_s1);
			if (adv_s1) begin
				run_q <= run_next;
				if (flush_s1) begin
					prev_q      <= StartPixel;
					entry_vld_q <= '0;
				end else if (tbl_wr) begin
					prev_q               <= px_s1;
					entry_vld_q[slot_s1] <= 1'b1;
					last_wr_vld_q        <= 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Stage 2: byte shifter
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2 <= '0;
		end else if (adv_s1 && nbytes != '0) begin
			rem_s2 <= nbytes;
		end else if (out_fire) begin
			rem_s2 <= rem_s2 - CountW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && nbytes != '0) begin
			bytes_s2 <= nb;
		end else if (out_fire) begin
			bytes_s2 <= {8'h00, bytes_s2[MaxBytes-1:1]};
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// testbench: self-checking stream test of qoi_pixel_encoder_core against an in-bench QOI encoder.
module testbench;
	import qpe_pkg::*;

	localparam int RunLimit = 62;
	localparam int QuietLimit = 1000;   // cycles with no beat on either side
	localparam int TailCycles = 20;     // settle time once every byte is in
	localparam logic OpPixel = 1'b0;
	localparam logic OpFlush = 1'b1;

	typedef struct {
		logic [7:0] code;
		logic       last;
	} chunk_byte_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       op = OpPixel;
	logic [7:0] red = 8'd0;
	logic [7:0] green = 8'd0;
	logic [7:0] blue = 8'd0;
	logic [7:0] alpha = 8'd0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] code_byte;
	logic       last_byte;

	// encoder state as the bench sees it
	pixel_t      last_px;
	pixel_t      colour_cache [TableDepth];
	int          run_cnt;
	pixel_t      recent_px [$];
	chunk_byte_t chunk_bytes_due [$];
	chunk_byte_t got_want;

	bit tx_gaps = 1'b0;
	bit rx_gaps = 1'b0;
	int fail_count = 0;
	int quiet_cycles = 0;
	int stall_hold = 0;
	int stall_pick;

	qoi_pixel_encoder_core #(.RUN_LIMIT(RunLimit)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.code_byte(code_byte),
		.last_byte(last_byte)
	);

	always #2 clk = ~clk;

	function automatic pixel_t mk_px(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic [7:0] a);
		pixel_t p;
		p.r = r;
		p.g = g;
		p.b = b;
		p.a = a;
		return p;
	endfunction

	// channel delta mod 256, read as a signed byte
	function automatic int wrap_delta(logic [7:0] now_v, logic [7:0] old_v);
		logic [7:0] d;
		d = now_v - old_v;
		return int'($signed(d));
	endfunction

	task automatic clear_encoder_state();
		last_px = mk_px(8'd0, 8'd0, 8'd0, 8'd255);
		foreach (colour_cache[i])
			colour_cache[i] = '0;
		run_cnt = 0;
	endtask

	// Work out the chunk bytes one accepted beat produces and queue them.
	task automatic qoi_encode_item(logic f, pixel_t px);
		chunk_byte_t bytes_out [$];
		int slot;
		int dr, dg, db, dgr, dgb;
		if (f == OpFlush) begin
			if (run_cnt > 0)
				bytes_out.push_back('{ChunkRun | 8'(run_cnt - 1), 1'b0});
			clear_encoder_state();
		end else if (px == last_px) begin
			run_cnt++;
			if (run_cnt >= RunLimit) begin
				bytes_out.push_back('{ChunkRun | 8'(run_cnt - 1), 1'b0});
				run_cnt = 0;
			end
		end else begin
			if (run_cnt > 0) begin
				bytes_out.push_back('{ChunkRun | 8'(run_cnt - 1), 1'b0});
				run_cnt = 0;
			end
			slot = (int'(px.r) * 3 + int'(px.g) * 5 + int'(px.b) * 7 + int'(px.a) * 11) % 64;
			dr = wrap_delta(px.r, last_px.r);
			dg = wrap_delta(px.g, last_px.g);
			db = wrap_delta(px.b, last_px.b);
			dgr = dr - dg;
			dgb = db - dg;
			if (colour_cache[slot] == px) begin
				bytes_out.push_back('{ChunkIndex | 8'(slot), 1'b0});
			end else if (px.a == last_px.a) begin
				if (dr >= -2 && dr <= 1 && dg >= -2 && dg <= 1 && db >= -2 && db <= 1) begin
					bytes_out.push_back('{ChunkDiff |
						8'((dr + 2) * 16 + (dg + 2) * 4 + (db + 2)), 1'b0});
				end else if (dg >= -32 && dg <= 31 && dgr >= -8 && dgr <= 7 &&
						dgb >= -8 && dgb <= 7) begin
					bytes_out.push_back('{ChunkLuma | 8'(dg + 32), 1'b0});
					bytes_out.push_back('{8'((dgr + 8) * 16 + (dgb + 8)), 1'b0});
				end else begin
					bytes_out.push_back('{ChunkRgb, 1'b0});
					bytes_out.push_back('{px.r, 1'b0});
					bytes_out.push_back('{px.g, 1'b0});
					bytes_out.push_back('{px.b, 1'b0});
				end
			end else begin
				bytes_out.push_back('{ChunkRgba, 1'b0});
				bytes_out.push_back('{px.r, 1'b0});
				bytes_out.push_back('{px.g, 1'b0});
				bytes_out.push_back('{px.b, 1'b0});
				bytes_out.push_back('{px.a, 1'b0});
			end
			last_px = px;
			colour_cache[slot] = px;
		end
		if (bytes_out.size() > 0)
			bytes_out[$].last = 1'b1;
		foreach (bytes_out[i])
			chunk_bytes_due.push_back(bytes_out[i]);
	endtask

	function automatic int pick_gap();
		int r;
		if (!tx_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Send one beat; entered and left at a falling edge.
	task automatic send_beat(logic f, pixel_t px);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		op <= f;
		red <= px.r;
		green <= px.g;
		blue <= px.b;
		alpha <= px.a;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		qoi_encode_item(f, px);
		if (f == OpPixel) begin
			recent_px.push_back(px);
			if (recent_px.size() > 32)
				void'(recent_px.pop_front());
		end
		@(negedge clk);
	endtask

	task automatic send_pixel(pixel_t px);
		send_beat(OpPixel, px);
	endtask

	task automatic send_flush();
		send_beat(OpFlush, pixel_t'($urandom));
	endtask

	// sender holds off until every queued byte has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (chunk_bytes_due.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Every chunk kind, channel extremes, wrap in both directions, flushes with and without
	// a run, and the all-zero pixel that hits the cleared table.
	task automatic test_directed();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		send_beat(OpFlush, mk_px(8'd0, 8'd0, 8'd0, 8'd0));   // nothing pending
		send_pixel(mk_px(8'd0, 8'd0, 8'd0, 8'd255));         // start pixel: run, no byte
		send_pixel(mk_px(8'd0, 8'd0, 8'd0, 8'd0));           // run byte, then index
		send_pixel(mk_px(8'd255, 8'd255, 8'd255, 8'd255));   // rgba
		send_pixel(mk_px(8'd254, 8'd0, 8'd254, 8'd255));     // diff, wraps both ways
		send_pixel(mk_px(8'd0, 8'd1, 8'd0, 8'd255));         // luma
		send_pixel(mk_px(8'd231, 8'd225, 8'd216, 8'd255));   // luma, dg = -32
		send_pixel(mk_px(8'd254, 8'd0, 8'd253, 8'd255));     // luma, dg = 31
		send_pixel(mk_px(8'd252, 8'd254, 8'd251, 8'd255));   // diff, all -2
		send_pixel(mk_px(8'd253, 8'd255, 8'd252, 8'd255));   // diff, all +1
		send_pixel(mk_px(8'd128, 8'd17, 8'd99, 8'd255));     // rgb
		send_pixel(mk_px(8'd255, 8'd255, 8'd255, 8'd255));   // index revisit
		send_pixel(mk_px(8'd0, 8'd0, 8'd0, 8'd0));           // index revisit
		send_pixel(mk_px(8'd0, 8'd0, 8'd0, 8'd128));         // alpha only changes
		repeat (3)
			send_pixel(mk_px(8'd0, 8'd0, 8'd0, 8'd128));
		send_beat(OpFlush, mk_px(8'd255, 8'd255, 8'd255, 8'd255));  // flush with run
		send_pixel(mk_px(8'd0, 8'd0, 8'd0, 8'd255));         // start pixel again after flush
		send_flush();
		send_flush();
		send_pixel(mk_px(8'h55, 8'hAA, 8'h55, 8'hAA));
		send_pixel(mk_px(8'hAA, 8'h55, 8'hAA, 8'h55));
	endtask

	// Runs up to and past the limit, back to back with no idling on either side.
	task automatic test_run_limit();
		pixel_t p;
		tx_gaps = 1'b0;
		rx_gaps = 1'b0;
		p = mk_px(8'd10, 8'd20, 8'd30, 8'd40);
		send_pixel(p);
		repeat (RunLimit + 1)
			send_pixel(p);                                   // limit byte, then one more
		send_pixel(mk_px(8'd11, 8'd20, 8'd30, 8'd40));
		p = mk_px(8'd11, 8'd20, 8'd30, 8'd40);
		repeat (RunLimit - 1)
			send_pixel(p);
		send_flush();                                       // longest run a flush can carry
	endtask

	// Sender pause until the byte stream is empty, under random stalls.
	task automatic test_drain_pause();
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		repeat (6)
			send_pixel(pixel_t'($urandom));
		wait_drained();
		repeat (4)
			send_pixel(pixel_t'($urandom));
		wait_drained();
	endtask

	// Pixel stream shaped like image data: runs, small steps, luma steps, revisits,
	// opaque and translucent noise, and the odd flush.
	task automatic test_random_stream();
		int n;
		int k;
		int mode;
		int dg, dr, db;
		pixel_t p;
		n = 0;
		while (n < 50) begin
			if (n % 20 < 2) begin
				tx_gaps = ($urandom_range(0, 3) != 0);
				rx_gaps = ($urandom_range(0, 3) != 0);
			end
			mode = $urandom_range(0, 99);
			if (mode < 20) begin
				k = ($urandom_range(0, 29) == 0) ? $urandom_range(55, 70) : $urandom_range(1, 6);
				p = last_px;
				repeat (k)
					send_pixel(p);
				n += k;
			end else begin
				if (mode < 40) begin
					p = last_px;
					p.r = p.r + 8'($urandom_range(0, 3)) - 8'd2;
					p.g = p.g + 8'($urandom_range(0, 3)) - 8'd2;
					p.b = p.b + 8'($urandom_range(0, 3)) - 8'd2;
				end else if (mode < 60) begin
					dg = int'($urandom_range(0, 63)) - 32;
					dr = dg + int'($urandom_range(0, 15)) - 8;
					db = dg + int'($urandom_range(0, 15)) - 8;
					p = last_px;
					p.r = p.r + 8'(dr);
					p.g = p.g + 8'(dg);
					p.b = p.b + 8'(db);
				end else if (mode < 72 && recent_px.size() > 0) begin
					p = recent_px[$urandom_range(0, recent_px.size() - 1)];
				end else if (mode < 84) begin
					p = pixel_t'($urandom);
					p.a = last_px.a;
				end else if (mode < 95) begin
					p = pixel_t'($urandom);
				end
				if (mode >= 95)
					send_flush();
				else
					send_pixel(p);
				n++;
			end
			if (n % 25 == 24)
				wait_drained();
		end
	endtask

	// Receiver stalls: mostly short, now and then a long one.
	always @(negedge clk) begin
		if (!arst_n || !rx_gaps) begin
			out_stall <= 1'b0;
			stall_hold <= 0;
		end else if (stall_hold > 0) begin
			stall_hold <= stall_hold - 1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 65) begin
				out_stall <= 1'b0;
				stall_hold <= $urandom_range(0, 4);
			end else if (stall_pick < 94) begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(0, 2);
			end else begin
				out_stall <= 1'b1;
				stall_hold <= $urandom_range(10, 40);
			end
		end
	end

	// Each byte beat against the oldest queued byte.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (chunk_bytes_due.size() == 0) begin
				$error("unexpected byte beat: code_byte %h last_byte %b", code_byte, last_byte);
				fail_count++;
			end else begin
				got_want = chunk_bytes_due.pop_front();
				if (code_byte !== got_want.code) begin
					$error("code_byte: expected %h, got %h", got_want.code, code_byte);
					fail_count++;
				end
				if (last_byte !== got_want.last) begin
					$error("last_byte: expected %b, got %b", got_want.last, last_byte);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long with no beat on either side means a hang.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		clear_encoder_state();
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_run_limit();
		test_drain_pause();
		test_random_stream();
		wait_drained();
		repeat (TailCycles) @(posedge clk);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
